// ===== rtl/pidh_pkg.sv =====
package pidh_pkg;

  localparam int GAIN_W      = 24;
  localparam int HEAD_W      = 24;
  localparam int DT_W        = 10;
  localparam int LIMIT_W     = 15;
  localparam int DRIVE_W     = 16;
  localparam int ERR_W       = 25;
  localparam int DERR_W      = 26;
  localparam int INTEG_W     = 48;
  localparam int PROD_W      = 49;
  localparam int SUM_W       = 64;
  localparam int TERM_W      = 62;
  localparam int FRAC_BITS   = 20;
  localparam int DRV_FULL_W  = SUM_W - FRAC_BITS;

  // shared divider: 72-bit dividend, 10-bit divisor, 4 quotient bits per cycle
  localparam int DIV_W       = 72;
  localparam int DVSR_W      = 10;
  localparam int DIV_BITS    = 4;
  localparam int DIV_ITER    = DIV_W / DIV_BITS;
  localparam int CNT_W       = $clog2(DIV_ITER);
  localparam int MS_PER_S    = 1000;

  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 32;
  localparam int M_TUSER_W   = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [GAIN_W-1:0]  RESET_GAIN_P = 24'd314573;
  localparam logic [GAIN_W-1:0]  RESET_GAIN_I = 24'd9437;
  localparam logic [GAIN_W-1:0]  RESET_GAIN_D = 24'd36700;
  localparam logic [HEAD_W-1:0]  RESET_TARGET = 24'd46080;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT  = 15'd25600;

  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT  = 3'd4;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] OP_MAG      = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL_EDT  = 4'd2;
  localparam logic [OP_W-1:0] OP_INTEG    = 4'd3;
  localparam logic [OP_W-1:0] OP_ADD_P    = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL_ILO  = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL_IHI  = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV_SETI = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV      = 4'd8;
  localparam logic [OP_W-1:0] OP_ADD_I    = 4'd9;
  localparam logic [OP_W-1:0] OP_D_X24    = 4'd10;
  localparam logic [OP_W-1:0] OP_DIV_SETD = 4'd11;
  localparam logic [OP_W-1:0] OP_ADD_D    = 4'd12;
  localparam logic [OP_W-1:0] OP_OUT      = 4'd13;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } cmd_t;

endpackage

// ===== rtl/pidh_regs.sv =====
module pidh_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pidh_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [pidh_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [pidh_pkg::GAIN_W-1:0]           gain_p,
  output logic [pidh_pkg::GAIN_W-1:0]           gain_i,
  output logic [pidh_pkg::GAIN_W-1:0]           gain_d,
  output logic signed [pidh_pkg::HEAD_W-1:0]    target_heading,
  output logic [pidh_pkg::LIMIT_W-1:0]          drive_limit
);
  import pidh_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= RESET_GAIN_P;
      gain_i         <= RESET_GAIN_I;
      gain_d         <= RESET_GAIN_D;
      target_heading <= RESET_TARGET;
      drive_limit    <= RESET_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GAIN_P: gain_p         <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I: gain_i         <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D: gain_d         <= cfg_data[GAIN_W-1:0];
        CFG_TARGET: target_heading <= cfg_data[HEAD_W-1:0];
        CFG_LIMIT:  drive_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pidh_ctrl.sv =====
module pidh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 zero_dt,
  output pidh_pkg::cmd_t       cmd
);
  import pidh_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MAG      = 4'd1;
  localparam logic [3:0] S_MUL_EDT  = 4'd2;
  localparam logic [3:0] S_INTEG    = 4'd3;
  localparam logic [3:0] S_ADD_P    = 4'd4;
  localparam logic [3:0] S_MUL_ILO  = 4'd5;
  localparam logic [3:0] S_MUL_IHI  = 4'd6;
  localparam logic [3:0] S_DIV_SETI = 4'd7;
  localparam logic [3:0] S_DIV_I    = 4'd8;
  localparam logic [3:0] S_ADD_I    = 4'd9;
  localparam logic [3:0] S_D_X24    = 4'd10;
  localparam logic [3:0] S_DIV_SETD = 4'd11;
  localparam logic [3:0] S_DIV_D    = 4'd12;
  localparam logic [3:0] S_ADD_D    = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_ITER - 1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op     = OP_MAG;
        state_next = S_MUL_EDT;
      end
      S_MUL_EDT: begin
        cmd.op     = OP_MUL_EDT;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.op     = OP_INTEG;
        state_next = S_ADD_P;
      end
      S_ADD_P: begin
        cmd.op     = OP_ADD_P;
        state_next = S_MUL_ILO;
      end
      S_MUL_ILO: begin
        cmd.op     = OP_MUL_ILO;
        state_next = S_MUL_IHI;
      end
      S_MUL_IHI: begin
        cmd.op     = OP_MUL_IHI;
        state_next = S_DIV_SETI;
      end
      S_DIV_SETI: begin
        cmd.op     = OP_DIV_SETI;
        state_next = S_DIV_I;
      end
      S_DIV_I: begin
        cmd.op = OP_DIV;
        if (cnt == CNT_LAST) begin
          state_next = S_ADD_I;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ADD_I: begin
        cmd.op     = OP_ADD_I;
        state_next = zero_dt ? S_OUT : S_D_X24;
      end
      S_D_X24: begin
        cmd.op     = OP_D_X24;
        state_next = S_DIV_SETD;
      end
      S_DIV_SETD: begin
        cmd.op     = OP_DIV_SETD;
        state_next = S_DIV_D;
      end
      S_DIV_D: begin
        cmd.op = OP_DIV;
        if (cnt == CNT_LAST) begin
          state_next = S_ADD_D;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ADD_D: begin
        cmd.op     = OP_ADD_D;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_OUT) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/pidh_datapath.sv =====
module pidh_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pidh_pkg::cmd_t                        cmd,
  input  logic [pidh_pkg::S_TDATA_W-1:0]        in_data,
  input  logic [pidh_pkg::GAIN_W-1:0]           gain_p,
  input  logic [pidh_pkg::GAIN_W-1:0]           gain_i,
  input  logic [pidh_pkg::GAIN_W-1:0]           gain_d,
  input  logic signed [pidh_pkg::HEAD_W-1:0]    target_heading,
  input  logic [pidh_pkg::LIMIT_W-1:0]          drive_limit,
  output logic                                  zero_dt,
  output logic [pidh_pkg::DRIVE_W-1:0]          left_drive,
  output logic [pidh_pkg::DRIVE_W-1:0]          right_drive,
  output logic                                  clamped,
  output logic                                  zero_interval
);
  import pidh_pkg::*;

  // item registers
  logic signed [ERR_W-1:0]   e;
  logic signed [DERR_W-1:0]  de;
  logic [DT_W-1:0]           dt;
  logic [ERR_W-1:0]          e_mag;
  logic [ERR_W-1:0]          de_mag;
  logic [INTEG_W-1:0]        im;
  logic                      i_neg;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W+4:0]         t24;
  logic [DIV_W-1:0]          quo;
  logic [DVSR_W-1:0]         rem;
  logic [DVSR_W-1:0]         divisor;
  logic signed [SUM_W-1:0]   sum;

  // loop state
  logic signed [ERR_W-1:0]   last_error;
  logic signed [INTEG_W-1:0] integral;

  logic signed [HEAD_W-1:0]  sample;
  logic [DT_W-1:0]           dt_in;
  logic signed [ERR_W-1:0]   e_in;
  logic signed [DERR_W-1:0]  de_in;

  logic [GAIN_W-1:0]         mul_a;
  logic [ERR_W-1:0]          mul_b;
  logic [PROD_W-1:0]         mul_res;
  logic                      prod_we;

  logic [PROD_W-1:0]         integ_ext;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;

  logic [DIV_W-1:0]          q_next;
  logic [DVSR_W-1:0]         r_next;
  logic [DVSR_W:0]           r_try;

  logic                      term_big;
  logic [TERM_W-1:0]         term;
  logic signed [SUM_W-1:0]   term_ext;

  logic signed [DRV_FULL_W-1:0] drive_full;
  logic signed [DRV_FULL_W-1:0] lim_pos;
  logic signed [DRV_FULL_W-1:0] lim_neg;
  logic signed [DRV_FULL_W-1:0] drive_sel;
  logic                         clamp_hit;

  assign sample = in_data[HEAD_W-1:0];
  assign dt_in  = in_data[HEAD_W +: DT_W];
  assign e_in   = ERR_W'(target_heading) - ERR_W'(sample);
  assign de_in  = DERR_W'(e_in) - DERR_W'(last_error);

  // shared multiplier, operands picked by step
  always_comb begin
    mul_a   = gain_d;
    mul_b   = de_mag;
    prod_we = 1'b0;
    case (cmd.op)
      OP_MUL_EDT: begin
        mul_a   = GAIN_W'(dt);
        mul_b   = e_mag;
        prod_we = 1'b1;
      end
      OP_INTEG: begin
        mul_a   = gain_p;
        mul_b   = e_mag;
        prod_we = 1'b1;
      end
      OP_MUL_ILO: begin
        mul_a   = gain_i;
        mul_b   = ERR_W'(im[GAIN_W-1:0]);
        prod_we = 1'b1;
      end
      OP_MUL_IHI: begin
        mul_a   = gain_i;
        mul_b   = ERR_W'(im[INTEG_W-1:GAIN_W]);
        prod_we = 1'b1;
      end
      OP_ADD_I: begin
        prod_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

  // integral update, saturating at 48 bits
  assign integ_ext = prod;
  always_comb begin
    if (e[ERR_W-1]) begin
      integ_sum = (INTEG_W+1)'(integral) - $signed(integ_ext);
    end else begin
      integ_sum = (INTEG_W+1)'(integral) + $signed(integ_ext);
    end
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  // restoring divider, DIV_BITS quotient bits per cycle
  always_comb begin
    q_next = quo;
    r_next = rem;
    r_try  = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      r_try  = {r_next, q_next[DIV_W-1]};
      q_next = {q_next[DIV_W-2:0], 1'b0};
      if (r_try >= {1'b0, divisor}) begin
        r_try     = r_try - {1'b0, divisor};
        q_next[0] = 1'b1;
      end
      r_next = r_try[DVSR_W-1:0];
    end
  end

  // term saturates at 2^61
  assign term_big = (|quo[DIV_W-1:TERM_W]) || (quo[TERM_W-1] && (|quo[TERM_W-2:0]));
  assign term     = term_big ? {1'b1, {(TERM_W-1){1'b0}}} : quo[TERM_W-1:0];
  assign term_ext = SUM_W'(term);

  // scale from Q20 (arithmetic shift floors) and clamp
  assign drive_full = sum[SUM_W-1:FRAC_BITS];
  assign lim_pos    = DRV_FULL_W'(drive_limit);
  assign lim_neg    = -lim_pos;
  always_comb begin
    drive_sel = drive_full;
    clamp_hit = 1'b0;
    if (drive_full > lim_pos) begin
      drive_sel = lim_pos;
      clamp_hit = 1'b1;
    end else if (drive_full < lim_neg) begin
      drive_sel = lim_neg;
      clamp_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integral   <= '0;
    end else if (cmd.op == OP_INTEG) begin
      last_error <= e;
      integral   <= integ_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e       <= e_in;
      de      <= de_in;
      dt      <= dt_in;
      zero_dt <= (dt_in == '0);
    end
    if (prod_we) begin
      prod <= mul_res;
    end
    case (cmd.op)
      OP_MAG: begin
        e_mag  <= e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
        de_mag <= de[DERR_W-1] ? ERR_W'(-de) : de[ERR_W-1:0];
      end
      OP_ADD_P: begin
        sum   <= e[ERR_W-1] ? -SUM_W'(prod) : SUM_W'(prod);
        im    <= integral[INTEG_W-1] ? INTEG_W'(-integral) : INTEG_W'(integral);
        i_neg <= integral[INTEG_W-1];
      end
      OP_MUL_IHI: begin
        quo <= DIV_W'(prod);
      end
      OP_DIV_SETI: begin
        quo     <= quo + {prod[PROD_W-2:0], {GAIN_W{1'b0}}};
        rem     <= '0;
        divisor <= DVSR_W'(MS_PER_S);
      end
      OP_DIV: begin
        quo <= q_next;
        rem <= r_next;
      end
      OP_ADD_I: begin
        sum <= i_neg ? sum - term_ext : sum + term_ext;
      end
      OP_D_X24: begin
        t24 <= {1'b0, prod, 4'b0} + {2'b0, prod, 3'b0};
      end
      OP_DIV_SETD: begin
        quo     <= DIV_W'({prod, 10'b0} - {5'b0, t24});
        rem     <= '0;
        divisor <= dt;
      end
      OP_ADD_D: begin
        sum <= de[DERR_W-1] ? sum - term_ext : sum + term_ext;
      end
      OP_OUT: begin
        left_drive    <= drive_sel[DRIVE_W-1:0];
        right_drive   <= DRIVE_W'(-drive_sel);
        clamped       <= clamp_hit;
        zero_interval <= zero_dt;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/pid_heading_controller_core.sv =====
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: heading_sample, interval_ms
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: left/right drive; tuser: flags
// cfg       in         cfg_we (no wait)              cfg_addr, cfg_data
//
// One item at a time, with two passes of the shared 4-bit-per-cycle divider
// (integral /1000, derivative /dt); zero interval_ms skips the derivative pass.
// Sync reset restores default registers, clears last error and integral.
// A finished item waits in the output register; the next item is accepted
// meanwhile and the sequencer holds before its output write until it drains.
module pid_heading_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [23:0] heading_sample, [33:24] interval_ms, [39:34] zero
  input  logic [pidh_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] left_drive, [31:16] right_drive
  output logic [pidh_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] clamped, [1] zero_interval
  output logic [pidh_pkg::M_TUSER_W-1:0]      m_axis_tuser,
  input  logic                                cfg_we,
  input  logic [pidh_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pidh_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pidh_pkg::*;

  logic [GAIN_W-1:0]        gain_p;
  logic [GAIN_W-1:0]        gain_i;
  logic [GAIN_W-1:0]        gain_d;
  logic signed [HEAD_W-1:0] target_heading;
  logic [LIMIT_W-1:0]       drive_limit;
  cmd_t                     cmd;
  logic                     zero_dt;
  logic [DRIVE_W-1:0]       left_drive;
  logic [DRIVE_W-1:0]       right_drive;
  logic                     clamped;
  logic                     zero_interval;

  pidh_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .target_heading (target_heading),
    .drive_limit    (drive_limit)
  );

  pidh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .zero_dt   (zero_dt),
    .cmd       (cmd)
  );

  pidh_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_data        (s_axis_tdata),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .target_heading (target_heading),
    .drive_limit    (drive_limit),
    .zero_dt        (zero_dt),
    .left_drive     (left_drive),
    .right_drive    (right_drive),
    .clamped        (clamped),
    .zero_interval  (zero_interval)
  );

  assign m_axis_tdata = {right_drive, left_drive};
  assign m_axis_tuser = {zero_interval, clamped};

endmodule

// ===== tb/pid_heading_controller_core_tb.sv =====
`timescale 1ns / 100ps

module pid_heading_controller_core_tb;
  import pidh_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] left;
    logic [DRIVE_W-1:0] right;
    logic               clamped;
    logic               zero_dt;
  } drive_t;

  localparam u64_t   KMS       = 64'd1000;
  localparam u64_t   TERM_CAP  = 64'h2000_0000_0000_0000;
  localparam longint INTEG_HI  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_LO  = -64'sh0000_8000_0000_0000;
  localparam int     NUM_REGS  = 1 << CFG_ADDR_W;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [23:0] heading_sample, [33:24] interval_ms, [39:34] zero
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [15:0] left_drive, [31:16] right_drive
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // [0] clamped, [1] zero_interval
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // controller shadow
  logic [GAIN_W-1:0]         gp_r  = RESET_GAIN_P;
  logic [GAIN_W-1:0]         gi_r  = RESET_GAIN_I;
  logic [GAIN_W-1:0]         gd_r  = RESET_GAIN_D;
  logic signed [HEAD_W-1:0]  tgt_r = RESET_TARGET;
  logic [LIMIT_W-1:0]        lim_r = RESET_LIMIT;
  longint                    prev_err  = 0;
  longint                    integ_acc = 0;

  drive_t drive_q[$];
  int     err_count = 0;
  bit     src_idle_on = 1'b1;
  bit     snk_idle_on = 1'b1;
  int     hold_req = 0;

  pid_heading_controller_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic drive_t predict_drive(input logic signed [HEAD_W-1:0] sample,
                                           input logic [DT_W-1:0] dt);
    longint e, de, sum, drv, ndrv, lim;
    u64_t   im, iterm, dmag, dterm;
    drive_t res;
    e  = longint'(tgt_r) - longint'(sample);
    de = e - prev_err;

    integ_acc = integ_acc + e * longint'(dt);
    if (integ_acc > INTEG_HI) integ_acc = INTEG_HI;
    if (integ_acc < INTEG_LO) integ_acc = INTEG_LO;

    sum = longint'(gp_r) * e;

    im    = (integ_acc < 0) ? -integ_acc : integ_acc;
    iterm = gi_r * (im / KMS) + (gi_r * (im % KMS)) / KMS;
    if (iterm > TERM_CAP) iterm = TERM_CAP;
    sum = sum + ((integ_acc < 0) ? -longint'(iterm) : longint'(iterm));

    if (dt != 0) begin
      dmag  = (de < 0) ? -de : de;
      dterm = gd_r * dmag * KMS / dt;
      if (dterm > TERM_CAP) dterm = TERM_CAP;
      sum = sum + ((de < 0) ? -longint'(dterm) : longint'(dterm));
    end

    drv = sum >>> FRAC_BITS;
    lim = longint'(lim_r);
    res.clamped = 1'b0;
    if (drv > lim) begin
      drv = lim;
      res.clamped = 1'b1;
    end else if (drv < -lim) begin
      drv = -lim;
      res.clamped = 1'b1;
    end
    ndrv = -drv;
    res.left    = drv[DRIVE_W-1:0];
    res.right   = ndrv[DRIVE_W-1:0];
    res.zero_dt = (dt == 0);
    prev_err = e;
    return res;
  endfunction

  // mostly short, a few long
  function automatic int rand_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int pick_gap();
    if (!src_idle_on || $urandom_range(0, 99) < 55) return 0;
    return rand_stall();
  endfunction

  task automatic send_item(input logic signed [HEAD_W-1:0] sample,
                           input logic [DT_W-1:0] dt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-HEAD_W-DT_W){1'b0}}, dt, sample};
    do @(posedge clk); while (!s_axis_tready);
    drive_q.push_back(predict_drive(sample, dt));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P: gp_r  = value;
      CFG_GAIN_I: gi_r  = value;
      CFG_GAIN_D: gd_r  = value;
      CFG_TARGET: tgt_r = value;
      CFG_LIMIT:  lim_r = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                            input logic [GAIN_W-1:0] gd, input logic [HEAD_W-1:0] tgt,
                            input logic [LIMIT_W-1:0] lim);
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_LIMIT, {{(CFG_DATA_W-LIMIT_W){1'b0}}, lim});
  endtask

  // mostly samples near the setpoint, the rest raw noise
  task automatic send_random_item(input int emax);
    int     r;
    longint e, s_full;
    logic signed [HEAD_W-1:0] sample;
    logic [DT_W-1:0] dt;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      e = longint'($urandom_range(0, emax));
      if ($urandom_range(0, 1)) e = -e;
      s_full = longint'(tgt_r) - e;
      sample = s_full[HEAD_W-1:0];
      r = $urandom_range(0, 99);
      if (r < 6)       dt = '0;
      else if (r < 85) dt = DT_W'($urandom_range(10, 30));
      else if (r < 95) dt = DT_W'($urandom_range(1, 200));
      else if (r < 97) dt = 10'd1;
      else             dt = 10'd1023;
    end else begin
      sample = HEAD_W'($urandom());
      dt     = DT_W'($urandom());
    end
    send_item(sample, dt);
  endtask

  task automatic test_reset_defaults();
    send_item(RESET_TARGET, 10'd20);
    send_item(-24'sd8388608, 10'd1023);
    send_item(24'sd8388607, 10'd0);
    send_item(24'sd8388607, 10'd1);
    send_item(-24'sd8388608, 10'd1);
    send_item(RESET_TARGET + 24'sd100, 10'd20);
    wait_drain();
    // spare indexes must not disturb anything
    for (int a = CFG_LIMIT + 1; a < NUM_REGS; a++)
      write_reg(a[CFG_ADDR_W-1:0], 24'hFFFFFF);
    send_item(RESET_TARGET - 24'sd300, 10'd25);
  endtask

  task automatic test_clamp_boundary();
    wait_drain();
    set_config(24'd1 << FRAC_BITS, '0, '0, '0, 15'd100);
    send_item(-24'sd100, 10'd0);
    send_item(-24'sd101, 10'd7);
    send_item(24'sd100, 10'd0);
    send_item(24'sd101, 10'd3);
    wait_drain();
    write_reg(CFG_LIMIT, 24'd0);
    send_item(-24'sd1, 10'd5);
    send_item(24'sd0, 10'd0);
    wait_drain();
    write_reg(CFG_LIMIT, 24'd32767);
    send_item(-24'sd32767, 10'd0);
    send_item(-24'sd40000, 10'd9);
    send_item(24'sd40000, 10'd0);
    wait_drain();
    // half gain: odd errors expose the rounding direction
    write_reg(CFG_GAIN_P, 24'd1 << (FRAC_BITS - 1));
    send_item(24'sd1, 10'd0);
    send_item(-24'sd1, 10'd0);
    wait_drain();
    set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h800000, RESET_LIMIT);
    send_item(24'sd8388607, 10'd1023);
    send_item(-24'sd8388608, 10'd1);
  endtask

  task automatic test_config_sweep();
    int emax;
    for (int ph = 0; ph < 8; ph++) begin
      wait_drain();
      src_idle_on = 1'b1;
      snk_idle_on = 1'b1;
      case (ph)
        0: begin
          set_config(RESET_GAIN_P, RESET_GAIN_I, RESET_GAIN_D, RESET_TARGET, RESET_LIMIT);
          emax = 4000;
        end
        1: begin
          set_config(GAIN_W'($urandom_range(0, 24'h1FFFFF)),
                     GAIN_W'($urandom_range(0, 24'h1FFFFF)),
                     GAIN_W'($urandom_range(0, 24'h1FFFFF)), HEAD_W'($urandom()),
                     LIMIT_W'($urandom_range(0, 25600)));
          emax = 2000;
        end
        2: begin
          set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, RESET_LIMIT);
          emax = 64;
        end
        3: begin
          set_config('0, '0, '0, HEAD_W'($urandom()), RESET_LIMIT);
          emax = 100000;
          src_idle_on = 1'b0;
          snk_idle_on = 1'b0;
        end
        4: begin
          set_config(GAIN_W'($urandom_range(0, 24'h03FFFF)),
                     GAIN_W'($urandom_range(0, 24'h00FFFF)),
                     GAIN_W'($urandom_range(24'h800000, 24'hFFFFFF)),
                     HEAD_W'($urandom()), 15'd32767);
          emax = 300;
        end
        5: begin
          set_config(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()),
                     HEAD_W'($urandom()), LIMIT_W'($urandom_range(0, 32767)));
          emax = int'($urandom_range(10, 8000));
        end
        6: begin
          set_config(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()),
                     24'h800000, 15'd0);
          emax = 500;
        end
        default: begin
          set_config(RESET_GAIN_P, RESET_GAIN_I, RESET_GAIN_D, RESET_TARGET, RESET_LIMIT);
          emax = 20000;
          snk_idle_on = 1'b0;
        end
      endcase
      repeat (200) send_random_item(emax);
    end
  endtask

  task automatic test_backpressure();
    wait_drain();
    src_idle_on = 1'b0;
    hold_req    = 400;
    repeat (12) send_random_item(3000);
    wait_drain();
    src_idle_on = 1'b1;
  endtask

  task automatic test_integral_saturation();
    wait_drain();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    set_config(GAIN_W'($urandom_range(0, 24'h0FFFFF)), 24'hFFFFFF,
               GAIN_W'($urandom_range(0, 24'h0FFFFF)), 24'h800000, RESET_LIMIT);
    for (int i = 0; i < 60; i++)
      send_item(24'sd8388607, (i % 16 == 5) ? 10'd0 : 10'd1023);
    wait_drain();
    write_reg(CFG_TARGET, 24'h7FFFFF);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    repeat (24) send_item(-24'sd8388608, 10'd1023);
  endtask

  initial begin : sink_proc
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 99) < 20) begin
        stall_left = rand_stall() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    drive_t got;
    drive_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0], m_axis_tuser[1]};
      if (drive_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected item: left %0d right %0d clamped %0b zero_dt %0b",
                   $signed(got.left), $signed(got.right), got.clamped, got.zero_dt);
      end else begin
        want = drive_q.pop_front();
        if (got.left !== want.left || got.right !== want.right ||
            got.clamped !== want.clamped || got.zero_dt !== want.zero_dt) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp left %0d right %0d clamped %0b zero_dt %0b,",
                     $signed(want.left), $signed(want.right), want.clamped, want.zero_dt,
                     " got left %0d right %0d clamped %0b zero_dt %0b",
                     $signed(got.left), $signed(got.right), got.clamped, got.zero_dt);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_clamp_boundary();
    test_config_sweep();
    test_backpressure();
    test_integral_saturation();
    wait_drain();
    repeat (60) @(posedge clk);
    if (err_count == 0 && drive_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
